// File: src/mkts_pkg.sv
// Shared types and constants for the top-k key threshold search block.
`default_nettype none
package mkts_pkg;
    localparam int KEY_W = 31;
    localparam int VAL_W = 16;
    localparam int K_W   = 11;
    localparam int CFG_W = 31;
    localparam int SUM_W = 32;
    localparam int HK_W  = KEY_W + VAL_W;

    localparam logic CFG_ITEMS_TO_PICK = 1'b0;
    localparam logic CFG_SUM_THRESHOLD = 1'b1;

    typedef enum logic [3:0] {
        H_IDLE, H_PU_UP, H_PU_CMP, H_PO_TOP, H_PO_LAST,
        H_PO_DN, H_PO_C1, H_PO_C2, H_PO_CMP
    } t_heap_state;

    typedef enum logic [3:0] {
        S_IDLE, S_KPUSH, S_POPK, S_WAITK, S_WAITP, S_POPP, S_WAITD, S_CHECK, S_FINISH
    } t_top_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic clr;
    } t_heap_cmd;
endpackage
`default_nettype wire

// File: src/min_key_for_topk_sum_threshold.sv
// Top level: key heap, pick heap and the search sequencer.
`default_nettype none
// Usage: configure items_to_pick (index 0) and sum_threshold (index 1) through
// the write port while idle. Each item is a transfer on start while busy is low.
// An item not marked last is pushed into the key heap, sifting up through the
// heap memory one level at a time.
// An item that meets a full key heap is dropped without a push.
// An item marked last is pushed if there is room, then the key heap is drained
// in key order until K values summing to at least the threshold are held or it
// is empty; every popped value is pushed into the pick heap and, when more than
// K are held, the smallest is popped. Pops sift down, pushes sift up.
// The result appears for one cycle on o_found/o_answer_key with o_valid high;
// the receiver cannot stall. After the result both heaps, the running sum and
// the largest key return to empty; the registers keep their values.
// Reset (synchronous, active low) empties the heaps and sets K to 1 and the
// threshold to 0. Items arriving while the key heap is full are dropped.
module min_key_for_topk_sum_threshold import mkts_pkg::*; #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [VAL_W-1:0] i_item_value,
    input  wire logic [KEY_W-1:0] i_item_key,
    input  wire logic             i_last_item,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    output logic                  o_valid,
    output logic                  o_found,
    output logic      [KEY_W-1:0] o_answer_key
);
    localparam int CW = $clog2(MAX_ITEMS+1);
    localparam int XW = (CW > K_W) ? CW : K_W;

    t_top_state r_state, n_state;
    logic [K_W-1:0]   r_k;
    logic [KEY_W-1:0] r_thr, r_largest;
    logic [SUM_W-1:0] r_sum;
    logic             r_last;

    t_heap_cmd        kcmd, pcmd;
    logic             kdone, pdone;
    logic [HK_W-1:0]  ktop;
    logic [VAL_W-1:0] ptop, pv;
    logic [CW-1:0]    kcnt, pcnt;
    logic [KEY_W-1:0] pk;
    logic [SUM_W:0]   sum_add;
    logic             hit;
    logic             kfull;

    assign pk      = ktop[HK_W-1:VAL_W];
    assign pv      = ~ktop[VAL_W-1:0];
    assign sum_add = {1'b0, r_sum} + (SUM_W+1)'(pv);
    assign hit     = (XW'(pcnt) == XW'(r_k)) && (r_sum >= SUM_W'(r_thr));
    assign kfull   = kcnt == CW'(MAX_ITEMS);

    mkts_heap #(.W(HK_W), .DEPTH(MAX_ITEMS)) u_key_heap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (kcmd),
        .i_data ({i_item_key, ~i_item_value}),
        .o_done (kdone),
        .o_top  (ktop),
        .o_count(kcnt)
    );

    mkts_heap #(.W(VAL_W), .DEPTH(MAX_ITEMS)) u_pick_heap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (pcmd),
        .i_data (pv),
        .o_done (pdone),
        .o_top  (ptop),
        .o_count(pcnt)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                // a full key heap drops the item at once
                if (start) n_state = !kfull ? S_KPUSH : (i_last_item ? S_POPK : S_IDLE);
            end
            S_KPUSH:  if (kdone) n_state = r_last ? S_POPK : S_IDLE;
            S_POPK:   n_state = (kcnt == '0) ? S_FINISH : S_WAITK;
            S_WAITK:  if (kdone) n_state = S_WAITP;
            S_WAITP:  if (pdone) n_state = (XW'(pcnt) > XW'(r_k)) ? S_POPP : S_CHECK;
            S_POPP:   n_state = S_WAITD;
            S_WAITD:  if (pdone) n_state = S_CHECK;
            S_CHECK:  n_state = hit ? S_FINISH : S_POPK;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        kcmd = '0;
        pcmd = '0;
        unique case (r_state)
            S_IDLE:   kcmd.push = start && !kfull;
            S_POPK:   kcmd.pop  = kcnt != '0;
            S_WAITK:  pcmd.push = kdone;
            S_POPP:   pcmd.pop  = 1'b1;
            S_FINISH: begin
                kcmd.clr = 1'b1;
                pcmd.clr = 1'b1;
            end
            default: ;
        endcase
    end

    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= K_W'(1);
            r_thr     <= '0;
            r_sum     <= '0;
            r_largest <= '0;
            o_valid   <= 1'b0;
            o_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ITEMS_TO_PICK: r_k   <= i_cfg_wdata[K_W-1:0];
                    CFG_SUM_THRESHOLD: r_thr <= i_cfg_wdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (start) r_last <= i_last_item;
                S_WAITK: begin
                    if (kdone) begin
                        r_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                        if (pk > r_largest) r_largest <= pk;
                    end
                end
                S_WAITD: begin
                    if (pdone) begin
                        r_sum <= (r_sum >= SUM_W'(ptop)) ? r_sum - SUM_W'(ptop) : '0;
                    end
                end
                S_POPK: begin
                    if (kcnt == '0) begin
                        o_found      <= 1'b0;
                        o_answer_key <= '0;
                    end
                end
                S_CHECK: begin
                    if (hit) begin
                        o_found      <= 1'b1;
                        o_answer_key <= r_largest;
                    end
                end
                S_FINISH: begin
                    o_valid   <= 1'b1;
                    r_sum     <= '0;
                    r_largest <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/mkts_ram.sv
// Simple dual-port RAM with registered read.
`default_nettype none
module mkts_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/mkts_heap.sv
// Memory-held min-heap: push sifts up, pop sifts down, one level at a time.
`default_nettype none
module mkts_heap import mkts_pkg::*; #(
    parameter int W     = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_heap_cmd                  i_cmd,
    input  wire logic [W-1:0]               i_data,
    output logic                            o_done,
    output logic      [W-1:0]               o_top,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_heap_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_i, r_c;
    logic [W-1:0]  r_v, r_best, r_top;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, rd;
    logic [AW:0]   cw, m_ext;
    logic [AW-1:0] par;
    logic          c_in, c2_in, full;

    assign cw    = {r_i, 1'b1};
    assign m_ext = (AW+1)'(r_cnt);
    assign c_in  = cw < m_ext;
    assign c2_in = ({1'b0, r_c} + 1'b1) < m_ext;
    assign par   = AW'((r_i - 1'b1) >> 1);
    assign full  = r_cnt == CW'(DEPTH);

    mkts_ram #(.W(W), .D(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.push && !full) n_state = H_PU_UP;
                else if (i_cmd.pop)     n_state = H_PO_TOP;
            end
            H_PU_UP:   n_state = (r_i == '0) ? H_IDLE : H_PU_CMP;
            H_PU_CMP:  n_state = (rd <= r_v) ? H_IDLE : H_PU_UP;
            H_PO_TOP:  n_state = (r_cnt == '0) ? H_IDLE : H_PO_LAST;
            H_PO_LAST: n_state = H_PO_DN;
            H_PO_DN:   n_state = c_in ? H_PO_C1 : H_IDLE;
            H_PO_C1:   n_state = c2_in ? H_PO_C2 : H_PO_CMP;
            H_PO_C2:   n_state = H_PO_CMP;
            H_PO_CMP:  n_state = (r_best >= r_v) ? H_IDLE : H_PO_DN;
            default:   n_state = H_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_v;
        ram_raddr = '0;
        o_done    = 1'b0;
        unique case (r_state)
            H_IDLE: begin
                o_done = i_cmd.push && full;
            end
            H_PU_UP: begin
                ram_raddr = par;
                if (r_i == '0) begin
                    ram_we = 1'b1;
                    o_done = 1'b1;
                end
            end
            H_PU_CMP: begin
                ram_we = 1'b1;
                if (rd <= r_v) o_done = 1'b1;
                else           ram_wdata = rd;
            end
            H_PO_TOP: begin
                ram_raddr = AW'(r_cnt);
                o_done    = r_cnt == '0;
            end
            H_PO_DN: begin
                ram_raddr = AW'(cw);
                if (!c_in) begin
                    ram_we = 1'b1;
                    o_done = 1'b1;
                end
            end
            H_PO_C1: begin
                ram_raddr = r_c + 1'b1;
            end
            H_PO_CMP: begin
                ram_we = 1'b1;
                if (r_best >= r_v) o_done = 1'b1;
                else               ram_wdata = r_best;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cmd.clr && r_state == H_IDLE) r_cnt <= '0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_cmd.push && !full) begin
                        r_i   <= AW'(r_cnt);
                        r_cnt <= r_cnt + 1'b1;
                        r_v   <= i_data;
                    end else if (i_cmd.pop) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                H_PU_CMP:  if (!(rd <= r_v)) r_i <= r_c;
                H_PU_UP:   r_c <= par;
                H_PO_TOP:  r_top <= rd;
                H_PO_LAST: begin
                    r_v <= rd;
                    r_i <= '0;
                end
                H_PO_DN:   r_c <= AW'(cw);
                H_PO_C1:   r_best <= rd;
                H_PO_C2: begin
                    if (rd < r_best) begin
                        r_best <= rd;
                        r_c    <= r_c + 1'b1;
                    end
                end
                H_PO_CMP:  r_i <= r_c;
                default: ;
            endcase
        end
    end

    // a pop of the only entry finishes in H_PO_TOP, before r_top is loaded
    assign o_top   = (r_state == H_PO_TOP) ? rd : r_top;
    assign o_count = r_cnt;
endmodule
`default_nettype wire
